@@ rtl/sfjb_pkg.sv @@
package sfjb_pkg;

  localparam int unsigned SlotsDef      = 64;
  localparam int unsigned FrameWordsDef = 40;
  localparam int unsigned SeqW          = 32;
  localparam int unsigned IdxW          = 6;
  localparam int unsigned DataW         = 32;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_CHECK,
    ST_PLAY
  } state_e;

  typedef struct packed {
    op_e               opcode;
    logic [SeqW-1:0]   frame_seq;
    logic [IdxW-1:0]   word_index;
    logic [DataW-1:0]  word_data;
  } in_word_t;

  typedef struct packed {
    logic [SeqW-1:0]   out_seq;
    logic [IdxW-1:0]   out_index;
    logic [DataW-1:0]  out_data;
    logic              out_last;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic [SeqW-1:0]   tag;
  } tag_ent_t;

endpackage

@@ rtl/sfjb_ram.sv @@
module sfjb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/sequenced_frame_jitter_buffer_core.sv @@
// Channel   Direction  Payload                  Handshake
// in        input      sfjb_pkg::in_word_t      in_valid_i / in_stall_o
// out       output     sfjb_pkg::out_word_t     out_valid_o / out_stall_i
//
// Store words are taken one per cycle while in the run state; the slot tag
// read-modify-write runs via the s1 stage, forwarding the previous tag write.
// A tick holds the input in the check state and, on a hit, in the play state,
// which issues one payload RAM read per played word, not while one is pending.
// After reset a clearing pass sweeps every tag RAM slot; input is held.
// Out stalls delay the playout reads; a stalled word holds in the output register.
module sequenced_frame_jitter_buffer_core #(
  parameter int unsigned SLOTS       = sfjb_pkg::SlotsDef,
  parameter int unsigned FRAME_WORDS = sfjb_pkg::FrameWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfjb_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfjb_pkg::out_word_t out_word_o
);

  localparam int unsigned SlotW  = $clog2(SLOTS);
  localparam int unsigned Words  = SLOTS * FRAME_WORDS;
  localparam int unsigned PayAw  = $clog2(Words);
  localparam int unsigned TagEw  = $bits(sfjb_pkg::tag_ent_t);
  localparam int unsigned IdxW   = sfjb_pkg::IdxW;
  localparam int unsigned SeqW   = sfjb_pkg::SeqW;

  sfjb_pkg::state_e state_q, state_d;

  logic [SlotW-1:0] clr_q, clr_d;
  logic [SeqW-1:0]  play_seq_q, play_seq_d;
  logic [SlotW-1:0] play_slot_q, play_slot_d;

  logic             s1_valid_q, s1_valid_d;
  logic [SlotW-1:0] s1_slot_q, s1_slot_d;
  logic [SeqW-1:0]  s1_seq_q, s1_seq_d;
  logic             s1_last_q, s1_last_d;

  logic [SlotW-1:0] tag_raddr_q, tag_raddr_d;
  logic             fwd_en_q, fwd_en_d;
  logic [SlotW-1:0] fwd_addr_q, fwd_addr_d;
  sfjb_pkg::tag_ent_t fwd_data_q, fwd_data_d;

  logic [SeqW-1:0]  tick_seq_q, tick_seq_d;
  logic [PayAw-1:0] play_base_q, play_base_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic             rd_pend_q, rd_pend_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic             rd_last_q, rd_last_d;
  logic             out_valid_q, out_valid_d;
  sfjb_pkg::out_word_t out_q, out_d;

  logic             in_acc;
  logic             acc_store;
  logic             acc_tick;
  logic [SeqW-1:0]  diff;
  logic             in_win;
  logic             seq_wrap;
  logic             idx_ok;
  logic [SlotW:0]   slot_sum;
  logic [SlotW-1:0] st_slot;

  logic               tag_we;
  logic [SlotW-1:0]   tag_waddr;
  sfjb_pkg::tag_ent_t tag_wdata;
  logic [SlotW-1:0]   tag_raddr;
  logic [TagEw-1:0]   tag_rdata;
  sfjb_pkg::tag_ent_t tag_eff;
  logic               hit;

  logic             pay_we;
  logic [PayAw-1:0] pay_waddr;
  logic [PayAw-1:0] pay_raddr;
  logic [31:0]      pay_rdata;
  logic             issue;
  logic             issue_last;

  // store path
  assign in_acc    = in_valid_i && !in_stall_o;
  assign acc_store = in_acc && (in_word_i.opcode == sfjb_pkg::OP_STORE);
  assign acc_tick  = in_acc && (in_word_i.opcode == sfjb_pkg::OP_TICK);
  assign diff      = in_word_i.frame_seq - play_seq_q;
  assign in_win    = diff < SeqW'(SLOTS);
  assign seq_wrap  = in_word_i.frame_seq < play_seq_q;
  assign idx_ok    = {1'b0, in_word_i.word_index} < (IdxW + 1)'(FRAME_WORDS);
  assign slot_sum  = {1'b0, play_slot_q} + {1'b0, diff[SlotW-1:0]};

  always_comb begin
    if (seq_wrap) begin
      st_slot = in_word_i.frame_seq[SlotW-1:0];
    end else if (slot_sum >= (SlotW + 1)'(SLOTS)) begin
      st_slot = SlotW'(slot_sum - (SlotW + 1)'(SLOTS));
    end else begin
      st_slot = slot_sum[SlotW-1:0];
    end
  end

  assign pay_we    = acc_store && in_win && idx_ok;
  assign pay_waddr = PayAw'(st_slot) * PayAw'(FRAME_WORDS) + PayAw'(in_word_i.word_index);

  // tag read with forwarding of the previous write
  assign tag_raddr = acc_tick ? play_slot_q : st_slot;
  assign tag_eff   = (fwd_en_q && (fwd_addr_q == tag_raddr_q))
                     ? fwd_data_q : sfjb_pkg::tag_ent_t'(tag_rdata);
  assign hit       = tag_eff.valid && (tag_eff.tag == tick_seq_q);

  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = s1_slot_q;
    tag_wdata = '{valid: s1_last_q || (tag_eff.valid && (tag_eff.tag == s1_seq_q)),
                  tag: s1_seq_q};
    if (state_q == sfjb_pkg::ST_CLEAR) begin
      tag_we    = 1'b1;
      tag_waddr = clr_q;
      tag_wdata = '0;
    end else if (state_q == sfjb_pkg::ST_CHECK) begin
      tag_we    = 1'b1;
      tag_waddr = tag_raddr_q;
      tag_wdata = '{valid: 1'b0, tag: tag_eff.tag};
    end else if (s1_valid_q) begin
      tag_we    = 1'b1;
    end
  end

  sfjb_ram #(
    .Width (TagEw),
    .Depth (SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // playout reads
  assign issue      = (state_q == sfjb_pkg::ST_PLAY) && !rd_pend_q
                      && (!out_valid_q || !out_stall_i);
  assign issue_last = cnt_q == IdxW'(FRAME_WORDS - 1);
  assign pay_raddr  = play_base_q + PayAw'(cnt_q);

  sfjb_ram #(
    .Width (32),
    .Depth (Words)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (in_word_i.word_data),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfjb_pkg::ST_CLEAR: begin
        if (clr_q == SlotW'(SLOTS - 1)) begin
          state_d = sfjb_pkg::ST_RUN;
        end
      end
      sfjb_pkg::ST_RUN: begin
        if (acc_tick) begin
          state_d = sfjb_pkg::ST_CHECK;
        end
      end
      sfjb_pkg::ST_CHECK: begin
        state_d = hit ? sfjb_pkg::ST_PLAY : sfjb_pkg::ST_RUN;
      end
      sfjb_pkg::ST_PLAY: begin
        if (issue && issue_last) begin
          state_d = sfjb_pkg::ST_RUN;
        end
      end
      default: state_d = sfjb_pkg::ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_stall_o  = state_q != sfjb_pkg::ST_RUN;
    clr_d       = (state_q == sfjb_pkg::ST_CLEAR) ? clr_q + SlotW'(1) : clr_q;
    play_seq_d  = play_seq_q;
    play_slot_d = play_slot_q;
    tick_seq_d  = tick_seq_q;
    if (acc_tick) begin
      tick_seq_d = play_seq_q;
      play_seq_d = play_seq_q + SeqW'(1);
      if (play_seq_q == '1 || play_slot_q == SlotW'(SLOTS - 1)) begin
        play_slot_d = '0;
      end else begin
        play_slot_d = play_slot_q + SlotW'(1);
      end
    end

    s1_valid_d  = pay_we;
    s1_slot_d   = st_slot;
    s1_seq_d    = in_word_i.frame_seq;
    s1_last_d   = in_word_i.word_index == IdxW'(FRAME_WORDS - 1);
    tag_raddr_d = tag_raddr;
    fwd_en_d    = tag_we;
    fwd_addr_d  = tag_waddr;
    fwd_data_d  = tag_wdata;

    play_base_d = play_base_q;
    cnt_d       = cnt_q;
    if (state_q == sfjb_pkg::ST_CHECK) begin
      play_base_d = PayAw'(tag_raddr_q) * PayAw'(FRAME_WORDS);
      cnt_d       = '0;
    end else if (issue) begin
      cnt_d = cnt_q + IdxW'(1);
    end
    rd_pend_d = issue;
    rd_idx_d  = cnt_q;
    rd_last_d = issue_last;

    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (rd_pend_q) begin
      out_valid_d = 1'b1;
      out_d       = '{out_seq: tick_seq_q, out_index: rd_idx_q,
                      out_data: pay_rdata, out_last: rd_last_q};
    end

    out_valid_o = out_valid_q;
    out_word_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfjb_pkg::ST_CLEAR;
      clr_q       <= '0;
      play_seq_q  <= '0;
      play_slot_q <= '0;
      s1_valid_q  <= 1'b0;
      fwd_en_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      play_seq_q  <= play_seq_d;
      play_slot_q <= play_slot_d;
      s1_valid_q  <= s1_valid_d;
      fwd_en_q    <= fwd_en_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_slot_q   <= s1_slot_d;
    s1_seq_q    <= s1_seq_d;
    s1_last_q   <= s1_last_d;
    tag_raddr_q <= tag_raddr_d;
    fwd_addr_q  <= fwd_addr_d;
    fwd_data_q  <= fwd_data_d;
    tick_seq_q  <= tick_seq_d;
    play_base_q <= play_base_d;
    rd_idx_q    <= rd_idx_d;
    rd_last_q   <= rd_last_d;
    out_q       <= out_d;
  end

endmodule
